FILE: design/argbblend_pkg.sv
// ----------------------------------------------------------------------------
// argbblend_pkg
// Types, codes and per-pixel datapath functions for the ARGB8888-over-RGB565
// blend pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package argbblend_pkg;

   typedef struct packed {
      logic [31:0] src_pixel_a;
      logic [31:0] src_pixel_b;
      logic [15:0] dst_colour_a;
      logic [15:0] dst_colour_b;
      logic [7:0]  dst_alpha_pair;
   } req_type;

   typedef struct packed {
      logic [15:0] new_colour_a;
      logic [15:0] new_colour_b;
      logic [7:0]  new_alpha_pair;
   } rsp_type;

   typedef enum logic [1:0] {
      MODE_COPY = 2'd0,
      MODE_KEEP = 2'd1,
      MODE_MIX  = 2'd2
   } mode_type;

   localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;
   localparam logic [7:0]  ALPHA_CLEAR  = 8'h00;
   localparam logic [3:0]  NIB_FULL     = 4'h7;
   localparam logic [4:0]  RB_FULL      = 5'h1f;
   localparam logic [5:0]  G_FULL       = 6'h3f;

   // decoded pixel, ready for the scale multiply
   typedef struct packed {
      mode_type    mode;
      logic [7:0]  scale;
      logic [7:0]  dst_r;
      logic [7:0]  dst_g;
      logic [7:0]  dst_b;
      logic [8:0]  dst_a;
      logic [31:0] src;
      logic [15:0] dst;
      logic [3:0]  nib;
   } dec_type;

   // scaled destination channels
   typedef struct packed {
      mode_type    mode;
      logic [15:0] prod_r;
      logic [15:0] prod_g;
      logic [15:0] prod_b;
      logic [16:0] prod_a;
      logic [31:0] src;
      logic [15:0] dst;
      logic [3:0]  nib;
   } prod_type;

   typedef struct packed {
      logic [15:0] colour;
      logic [3:0]  nib;
   } px_type;

   function automatic dec_type blend_decode(input logic [31:0] src, input logic [15:0] dst,
                                            input logic [3:0] nib);
      dec_type d;
      d.src   = src;
      d.dst   = dst;
      d.nib   = nib;
      d.scale = 8'(~src[31:24] + 8'd1);
      d.dst_r = {dst[15:11], 3'b000};
      d.dst_g = {dst[10:5], 2'b00};
      d.dst_b = {dst[4:0], 3'b000};
      d.dst_a = {nib, 5'b00000};
      if (src[31:24] == ALPHA_OPAQUE) begin
         d.mode = MODE_COPY;
      end else if (src[31:24] == ALPHA_CLEAR) begin
         d.mode = MODE_KEEP;
      end else begin
         d.mode = MODE_MIX;
      end
      return d;
   endfunction

   function automatic prod_type blend_scale(input dec_type d);
      prod_type p;
      p.mode   = d.mode;
      p.src    = d.src;
      p.dst    = d.dst;
      p.nib    = d.nib;
      p.prod_r = 16'(d.scale * d.dst_r);
      p.prod_g = 16'(d.scale * d.dst_g);
      p.prod_b = 16'(d.scale * d.dst_b);
      p.prod_a = 17'(d.scale * d.dst_a);
      return p;
   endfunction

   function automatic px_type blend_finish(input prod_type p);
      px_type     o;
      logic [8:0] sum_r;
      logic [8:0] sum_g;
      logic [8:0] sum_b;
      logic [9:0] sum_a;
      sum_r = {1'b0, p.prod_r[15:8]} + {1'b0, p.src[23:16]};
      sum_g = {1'b0, p.prod_g[15:8]} + {1'b0, p.src[15:8]};
      sum_b = {1'b0, p.prod_b[15:8]} + {1'b0, p.src[7:0]};
      sum_a = {1'b0, p.prod_a[16:8]} + {2'b00, p.src[31:24]};
      case (p.mode)
         MODE_COPY: begin
            o.colour = {p.src[23:19], p.src[15:10], p.src[7:3]};
            o.nib    = NIB_FULL;
         end
         MODE_KEEP: begin
            o.colour = p.dst;
            o.nib    = p.nib;
         end
         MODE_MIX: begin
            o.colour[15:11] = sum_r[8] ? RB_FULL : sum_r[7:3];
            o.colour[10:5]  = sum_g[8] ? G_FULL : sum_g[7:2];
            o.colour[4:0]   = sum_b[8] ? RB_FULL : sum_b[7:3];
            o.nib           = (sum_a[9:8] != 2'b00) ? NIB_FULL : {1'b0, sum_a[7:5]};
         end
         default: begin
            o.colour = p.dst;
            o.nib    = p.nib;
         end
      endcase
      return o;
   endfunction

endpackage

`default_nettype wire

FILE: design/argb_over_rgb565_a3_blend.sv
// ----------------------------------------------------------------------------
// argb_over_rgb565_a3_blend
// Blends two ARGB8888 source pixels onto two RGB565 destination pixels that
// share one byte of 4-bit alpha nibbles.
// ----------------------------------------------------------------------------
// A request is taken on every clock where start is high; busy stays low, so
// one pixel pair enters per cycle. Each result appears on rsp_data with
// rsp_valid high for one cycle, in request order, after passing through the
// input register, the decode register, the channel multiply register and
// the saturate/output register.
`default_nettype none

module argb_over_rgb565_a3_blend (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   output logic                    busy,
   input  argbblend_pkg::req_type  req_data,
   output logic                    rsp_valid,
   output argbblend_pkg::rsp_type  rsp_data
);

   logic                      accept;
   logic                      in_valid_ff, dec_valid_ff, prod_valid_ff, out_valid_ff;
   argbblend_pkg::req_type    in_ff;
   argbblend_pkg::dec_type    dec_a_ff, dec_b_ff;
   argbblend_pkg::dec_type    dec_a_in, dec_b_in;
   argbblend_pkg::prod_type   prod_a_ff, prod_b_ff;
   argbblend_pkg::px_type     fin_a, fin_b;
   argbblend_pkg::rsp_type    out_ff, out_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      dec_a_in = argbblend_pkg::blend_decode(in_ff.src_pixel_a, in_ff.dst_colour_a,
                                             in_ff.dst_alpha_pair[7:4]);
      dec_b_in = argbblend_pkg::blend_decode(in_ff.src_pixel_b, in_ff.dst_colour_b,
                                             in_ff.dst_alpha_pair[3:0]);
      fin_a    = argbblend_pkg::blend_finish(prod_a_ff);
      fin_b    = argbblend_pkg::blend_finish(prod_b_ff);
      out_in.new_colour_a   = fin_a.colour;
      out_in.new_colour_b   = fin_b.colour;
      out_in.new_alpha_pair = {fin_a.nib, fin_b.nib};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         dec_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= accept;
         dec_valid_ff  <= in_valid_ff;
         prod_valid_ff <= dec_valid_ff;
         out_valid_ff  <= prod_valid_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_data;
      end
      if (in_valid_ff) begin
         dec_a_ff <= dec_a_in;
         dec_b_ff <= dec_b_in;
      end
      if (dec_valid_ff) begin
         prod_a_ff <= argbblend_pkg::blend_scale(dec_a_ff);
         prod_b_ff <= argbblend_pkg::blend_scale(dec_b_ff);
      end
      if (prod_valid_ff) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_valid)
      else $error("request did not produce a response after four cycles");

   a_no_phantom : assert property (@(posedge clock) disable iff (reset)
      !accept |-> ##4 !rsp_valid)
      else $error("response without a matching request");

   a_opaque_nib : assert property (@(posedge clock) disable iff (reset)
      (prod_valid_ff && prod_a_ff.mode == argbblend_pkg::MODE_COPY)
         |=> (rsp_data.new_alpha_pair[7:4] == argbblend_pkg::NIB_FULL))
      else $error("opaque source did not give a full alpha nibble");

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ARGB8888-over-RGB565 pixel pair blender. Pixel
// pairs are sent through the start/busy port, with random idle gaps in most phases. A local
// predictor computes each blended pair, and every rsp_valid strobe is checked
// field by field against the oldest outstanding request.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   start;
   logic                   busy;
   argbblend_pkg::req_type req_data;
   logic                   rsp_valid;
   argbblend_pkg::rsp_type rsp_data;

   argbblend_pkg::rsp_type blended_pairs_due[$];
   int                     mismatch_count;
   int                     gap_style;

   argb_over_rgb565_a3_blend u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void blend_pixel(input logic [31:0] src, input logic [15:0] dst,
                                       input logic [3:0] nib, output logic [15:0] colour,
                                       output logic [3:0] nib_out);
      int unsigned            alpha;
      int unsigned            weight;
      int unsigned            r;
      int unsigned            g;
      int unsigned            b;
      int unsigned            a;
      argbblend_pkg::mode_type mode;
      alpha = 32'(src[31:24]);
      mode  = (src[31:24] == argbblend_pkg::ALPHA_OPAQUE) ? argbblend_pkg::MODE_COPY :
              (src[31:24] == argbblend_pkg::ALPHA_CLEAR) ? argbblend_pkg::MODE_KEEP :
              argbblend_pkg::MODE_MIX;
      case (mode)
         argbblend_pkg::MODE_COPY: begin
            colour  = {src[23:19], src[15:10], src[7:3]};
            nib_out = argbblend_pkg::NIB_FULL;
         end
         argbblend_pkg::MODE_KEEP: begin
            colour  = dst;
            nib_out = nib;
         end
         default: begin
            weight = 256 - alpha;
            r = 32'(dst[15:11]);
            g = 32'(dst[10:5]);
            b = 32'(dst[4:0]);
            a = 32'(nib);
            r = ((weight * (r << 3)) >> 8) + 32'(src[23:16]);
            g = ((weight * (g << 2)) >> 8) + 32'(src[15:8]);
            b = ((weight * (b << 3)) >> 8) + 32'(src[7:0]);
            a = ((weight * (a << 5)) >> 8) + alpha;
            colour[15:11] = (r > 255) ? argbblend_pkg::RB_FULL : 5'(r >> 3);
            colour[10:5]  = (g > 255) ? argbblend_pkg::G_FULL : 6'(g >> 2);
            colour[4:0]   = (b > 255) ? argbblend_pkg::RB_FULL : 5'(b >> 3);
            nib_out       = (a > 255) ? argbblend_pkg::NIB_FULL : 4'(a >> 5);
         end
      endcase
   endfunction

   function automatic argbblend_pkg::rsp_type blend_pixel_pair(input argbblend_pkg::req_type r);
      argbblend_pkg::rsp_type p;
      logic [3:0]             nib_a;
      logic [3:0]             nib_b;
      blend_pixel(r.src_pixel_a, r.dst_colour_a, r.dst_alpha_pair[7:4], p.new_colour_a, nib_a);
      blend_pixel(r.src_pixel_b, r.dst_colour_b, r.dst_alpha_pair[3:0], p.new_colour_b, nib_b);
      p.new_alpha_pair = {nib_a, nib_b};
      return p;
   endfunction

   function automatic argbblend_pkg::req_type make_req(input logic [31:0] src_a,
                                                       input logic [31:0] src_b,
                                                       input logic [15:0] dst_a,
                                                       input logic [15:0] dst_b,
                                                       input logic [7:0] pair);
      argbblend_pkg::req_type r;
      r.src_pixel_a    = src_a;
      r.src_pixel_b    = src_b;
      r.dst_colour_a   = dst_a;
      r.dst_colour_b   = dst_b;
      r.dst_alpha_pair = pair;
      return r;
   endfunction

   function automatic int draw_gap();
      case (gap_style)
         0: return 0;
         1: return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 17) : 0;
         default: return $urandom_range(0, 17);
      endcase
   endfunction

   function automatic logic [31:0] random_pixel();
      logic [31:0] px;
      px = $urandom();
      case ($urandom_range(0, 9))
         0: px[31:24] = argbblend_pkg::ALPHA_CLEAR;
         1: px[31:24] = argbblend_pkg::ALPHA_OPAQUE;
         2: px[31:24] = 8'($urandom_range(1, 3));
         3: px[31:24] = 8'($urandom_range(252, 254));
         default: px[31:24] = 8'($urandom_range(1, 254));
      endcase
      return px;
   endfunction

   task automatic send_request(input argbblend_pkg::req_type r);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         @(negedge clock);
         start    <= 1'b0;
         req_data <= argbblend_pkg::req_type'({$urandom(), $urandom(), $urandom(),
                                               8'($urandom())});
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      blended_pairs_due.push_back(blend_pixel_pair(r));
   endtask

   // hold off until the pipeline has returned everything, or until the guard runs out
   task automatic wait_for_results();
      int guard;
      guard = 0;
      @(negedge clock);
      start <= 1'b0;
      while (blended_pairs_due.size() != 0 && guard < 2000) begin
         @(posedge clock);
         guard++;
      end
   endtask

   task automatic report_mismatch(input string field, input logic [15:0] want,
                                  input logic [15:0] got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: mismatch on %s: expected %h, got %h", $realtime, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      argbblend_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (blended_pairs_due.size() == 0) begin
            report_mismatch("unexpected result", 16'h0, rsp_data.new_colour_a);
         end else begin
            want = blended_pairs_due.pop_front();
            if (rsp_data.new_colour_a !== want.new_colour_a) begin
               report_mismatch("new_colour_a", want.new_colour_a, rsp_data.new_colour_a);
            end
            if (rsp_data.new_colour_b !== want.new_colour_b) begin
               report_mismatch("new_colour_b", want.new_colour_b, rsp_data.new_colour_b);
            end
            if (rsp_data.new_alpha_pair !== want.new_alpha_pair) begin
               report_mismatch("new_alpha_pair", 16'(want.new_alpha_pair),
                               16'(rsp_data.new_alpha_pair));
            end
         end
      end
   end

   task automatic test_field_extremes();
      send_request(make_req(32'h0000_0000, 32'h0000_0000, 16'h0000, 16'h0000, 8'h00));
      send_request(make_req(32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff, 8'hff));
      send_request(make_req(32'h00ff_ffff, 32'h00ff_ffff, 16'hffff, 16'hffff, 8'hff));
      send_request(make_req(32'h01ff_ffff, 32'hfe00_0000, 16'hffff, 16'h0000, 8'hf0));
      send_request(make_req(32'hfe00_0000, 32'h01ff_ffff, 16'h0000, 16'hffff, 8'h0f));
   endtask

   task automatic test_copy_and_keep();
      send_request(make_req(32'hff12_3456, 32'h0089_abcd, 16'h5a5a, 16'ha5a5, 8'h3c));
      send_request(make_req(32'h00fe_dcba, 32'hff07_0307, 16'h1234, 16'hfedc, 8'hc3));
      send_request(make_req(32'hff00_0000, 32'hff07_0307, 16'hffff, 16'hffff, 8'h00));
      send_request(make_req(32'h0000_0000, 32'h0000_0000, 16'h8421, 16'h7bde, 8'h9e));
   endtask

   task automatic test_partial_blend();
      send_request(make_req(32'h8090_9090, 32'h8070_7070, 16'hffff, 16'hffff, 8'h44));
      send_request(make_req(32'h80ff_00ff, 32'h8000_ff00, 16'hf81f, 16'h07e0, 8'h72));
      send_request(make_req(32'h4010_2030, 32'hc0f0_e0d0, 16'h7bef, 16'h8410, 8'h15));
      send_request(make_req(32'h0108_0408, 32'hfe08_0408, 16'h0841, 16'hf7be, 8'h27));
   endtask

   // mostly stored alpha nibbles above seven, kept or saturated to full
   task automatic test_nibble_overrange();
      send_request(make_req(32'hc800_0000, 32'h0000_0000, 16'h0000, 16'h0000, 8'hf8));
      send_request(make_req(32'h0100_0000, 32'h0100_0000, 16'h0000, 16'h0000, 8'h87));
      send_request(make_req(32'h2000_0000, 32'hf000_0000, 16'h1234, 16'h4321, 8'h9a));
      send_request(make_req(32'h0000_0000, 32'h0112_3456, 16'h0001, 16'hfffe, 8'hbf));
   endtask

   task automatic test_random_pairs(input int count);
      argbblend_pkg::req_type r;
      for (int i = 0; i < count; i++) begin
         if (i % 60 == 0) begin
            gap_style = $urandom_range(0, 2);
            if (i % 600 == 300) begin
               wait_for_results();
            end
         end
         r = make_req(random_pixel(), random_pixel(), 16'($urandom()), 16'($urandom()),
                      8'($urandom()));
         send_request(r);
      end
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      mismatch_count = 0;
      gap_style      = 2;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_field_extremes();
      gap_style = 0;
      test_copy_and_keep();
      wait_for_results();
      gap_style = 1;
      test_partial_blend();
      gap_style = 2;
      test_nibble_overrange();
      wait_for_results();
      test_random_pairs(1800);

      wait_for_results();
      repeat (10) @(posedge clock);
      if (blended_pairs_due.size() != 0) begin
         mismatch_count += blended_pairs_due.size();
         $display("%0d results never arrived", blended_pairs_due.size());
      end
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
